FILE: sv/eci_pkg.sv
// ----------------------------------------------------------------------------
// eci_pkg
// Shared types, constants and helpers for the easing curve interpolator.
// ----------------------------------------------------------------------------
package eci_pkg;

	localparam int VALUE_WIDTH   = 16;
	localparam int TIME_WIDTH    = 16;
	localparam int FRACTION_BITS = 8;
	localparam int OUT_WIDTH     = 24;

	// error codes
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_OPCODE   = 2'd1;
	localparam logic [1:0] ERR_DURATION = 2'd2;

	// curve families
	localparam logic [2:0] KIND_SINE   = 3'd0;
	localparam logic [2:0] KIND_QUAD   = 3'd1;
	localparam logic [2:0] KIND_CUBIC  = 3'd2;
	localparam logic [2:0] KIND_QUART  = 3'd3;
	localparam logic [2:0] KIND_QUINT  = 3'd4;
	localparam logic [2:0] KIND_EXPO   = 3'd5;
	localparam logic [2:0] KIND_CIRC   = 3'd6;
	localparam logic [2:0] KIND_BOUNCE = 3'd7;

	localparam logic [4:0] OP_LINEAR = 5'd0;
	localparam logic [4:0] OP_LAST   = 5'd24;

	// curve forms
	localparam logic [1:0] FORM_IN    = 2'd0;
	localparam logic [1:0] FORM_OUT   = 2'd1;
	localparam logic [1:0] FORM_INOUT = 2'd2;

	localparam logic [16:0] QONE  = 17'h10000;
	localparam logic [16:0] QHALF = 17'h08000;
	localparam logic signed [31:0] CORDIC_K    = 32'sd10188014;
	localparam logic [31:0]        HALF_PI_Q24 = 32'd26353589;

	typedef struct packed {
		logic [4:0]                     opcode;
		logic signed [VALUE_WIDTH-1:0]  start_value;
		logic signed [VALUE_WIDTH-1:0]  end_value;
		logic [TIME_WIDTH-1:0]          elapsed;
		logic [TIME_WIDTH-1:0]          duration;
	} eci_in_t;

	typedef struct packed {
		logic signed [OUT_WIDTH-1:0] eased_value;
		logic [1:0]                  error_code;
	} eci_out_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DIV,
		ST_PREP,
		ST_POW,
		ST_POW_W,
		ST_SIN_Z,
		ST_SIN_W,
		ST_SIN,
		ST_EXP_PRE,
		ST_EXP_SQ,
		ST_EXP_W,
		ST_EXP_FIN,
		ST_CIRC_SQ,
		ST_CIRC_W,
		ST_BNC_SQ,
		ST_BNC_W,
		ST_CURVE,
		ST_SCALE,
		ST_SCALE_W,
		ST_FINAL,
		ST_OUT
	} eci_state_t;

	// multiplier commands
	typedef struct packed {
		logic               start;
		logic signed [33:0] a;
		logic signed [33:0] b;
	} eci_mul_req_t;

	typedef struct packed {
		logic               done;
		logic signed [67:0] p;
	} eci_mul_rsp_t;

	function automatic logic signed [31:0] atan_q24(input logic [3:0] i);
		case (i)
			4'd0:    atan_q24 = 32'sd13176795;
			4'd1:    atan_q24 = 32'sd7778716;
			4'd2:    atan_q24 = 32'sd4110060;
			4'd3:    atan_q24 = 32'sd2086331;
			4'd4:    atan_q24 = 32'sd1047214;
			4'd5:    atan_q24 = 32'sd524117;
			4'd6:    atan_q24 = 32'sd262123;
			4'd7:    atan_q24 = 32'sd131069;
			4'd8:    atan_q24 = 32'sd65536;
			4'd9:    atan_q24 = 32'sd32768;
			4'd10:   atan_q24 = 32'sd16384;
			4'd11:   atan_q24 = 32'sd8192;
			4'd12:   atan_q24 = 32'sd4096;
			4'd13:   atan_q24 = 32'sd2048;
			4'd14:   atan_q24 = 32'sd1024;
			default: atan_q24 = 32'sd512;
		endcase
	endfunction

	// curve family of an opcode, by compares against multiples of three
	function automatic logic [2:0] op_kind(input logic [4:0] op);
		logic [4:0] t;
		t = op - 5'd1;
		op_kind = 3'd0;
		for (int k = 1; k < 8; k++)
			if (t >= 5'(3 * k))
				op_kind = 3'(k);
	endfunction

	// curve form of an opcode
	function automatic logic [1:0] op_form(input logic [4:0] op);
		logic [4:0] t;
		logic [2:0] k;
		t = op - 5'd1;
		k = op_kind(op);
		op_form = 2'(t - 5'(k) * 5'd3);
	endfunction

	function automatic logic [16:0] clamp_unit(input logic signed [39:0] v);
		if (v < 0)
			clamp_unit = 17'd0;
		else if (v > 40'sd65536)
			clamp_unit = QONE;
		else
			clamp_unit = v[16:0];
	endfunction

endpackage

FILE: sv/easing_curve_interpolator_unit.sv
// Error requests skip the arithmetic units; other requests use the 33-step
// divider, the serial multiplier and, for circ and expo, the 32-step square
// root (repeated 16 times for expo).
// Throughput: one request at a time; a new request is taken after the result
// has been handed off (the output register frees as it is taken).
// Reset: arst_n clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
// easing_curve_interpolator_unit
// Penner easing curves in fixed point, driven by a sequencer over shared
// serial divide, multiply and square-root units.
// ----------------------------------------------------------------------------
module easing_curve_interpolator_unit import eci_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  eci_in_t in_data,
	output logic    out_valid,
	input  logic    out_stall,
	output eci_out_t out_data
);

	eci_state_t state_q, state_d;

	// request registers
	logic [4:0]                    op_q;
	logic signed [VALUE_WIDTH-1:0] a_q, b_q;
	logic [2:0]                    kind_q;
	logic [1:0]                    form_q;
	logic [16:0]                   p_q;     // progress
	logic [17:0]                   x_q;     // curve argument
	logic signed [39:0]            r_q;     // general accumulator
	logic [2:0]                    pcnt_q;  // power steps left
	logic [3:0]                    it_q;    // iteration index
	logic signed [39:0]            cx_q, cy_q, cz_q;
	logic [16:0]                   ef_q;    // expo fraction
	logic [3:0]                    ek_q;    // expo shift
	logic [63:0]                   ey_q;
	logic [16:0]                   g_q;     // in-form curve value
	logic [16:0]                   f_q;     // final curve value
	logic signed [39:0]            badd_q;

	logic        div_start, div_done;
	logic [16:0] div_quo;
	logic        sq_start, sq_done;
	logic [63:0] sq_rad;
	logic [32:0] sq_root;
	eci_mul_req_t mreq;
	eci_mul_rsp_t mrsp;

	logic [TIME_WIDTH-1:0] el_sat;
	assign el_sat = (in_data.elapsed > in_data.duration) ? in_data.duration : in_data.elapsed;

	eci_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(el_sat), .den(in_data.duration), .done(div_done), .quo(div_quo)
	);
	eci_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .rsp(mrsp));
	eci_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.radicand(sq_rad), .done(sq_done), .root(sq_root)
	);

	logic accept;
	assign in_stall = (state_q != ST_IDLE) || out_valid;
	assign accept   = in_valid && !in_stall;
	assign div_start = accept && (in_data.opcode <= OP_LAST) && (in_data.duration != '0);

	// rounded product shifts
	function automatic logic signed [67:0] rsh(input logic signed [67:0] v, input int s);
		rsh = (v + (68'sd1 <<< (s - 1))) >>> s;
	endfunction

	// bounce segment
	logic signed [39:0] be, bu, badd;
	always_comb begin
		be = 40'sd11 * $signed({23'd0, x_q[16:0]});
		if (be < 40'sd262144) begin
			bu = be; badd = 40'sd0;
		end else if (be < 40'sd524288) begin
			bu = be - 40'sd393216; badd = 40'sd49152;
		end else if (be < 40'sd655360) begin
			bu = be - 40'sd589824; badd = 40'sd61440;
		end else begin
			bu = be - 40'sd688128; badd = 40'sd64512;
		end
	end

	// expo setup
	logic [20:0] em;
	logic [4:0]  ek;
	always_comb begin
		em = 21'd655360 - 21'(10 * x_q[16:0]);
		ek = 5'((em + 21'd65535) >> 16);
	end

	// CORDIC shifted terms
	logic signed [39:0] sx, sy;
	logic signed [31:0] at;
	assign sx = cx_q >>> it_q;
	assign sy = cy_q >>> it_q;
	assign at = atan_q24(it_q);

	// curve argument folded by form (in, out or in-out half)
	logic [17:0] arg_in;
	always_comb begin
		case (form_q)
			FORM_IN:  arg_in = {1'b0, p_q};
			FORM_OUT: arg_in = 18'(QONE - p_q);
			default:  arg_in = (p_q < QHALF) ? 18'({p_q, 1'b0}) : 18'({18'(QONE - p_q), 1'b0});
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (accept) state_d = div_start ? ST_DIV : ST_OUT;
			ST_DIV:     if (div_done) state_d = ST_PREP;
			ST_PREP: begin
				if (op_q == OP_LINEAR) state_d = ST_SCALE;
				else begin
					case (kind_q)
						KIND_SINE:   state_d = ST_SIN_Z;
						KIND_EXPO:   state_d = ST_EXP_PRE;
						KIND_CIRC:   state_d = ST_CIRC_SQ;
						KIND_BOUNCE: state_d = ST_BNC_SQ;
						default:     state_d = ST_POW;
					endcase
				end
			end
			ST_POW:     state_d = (pcnt_q == 3'd0) ? ST_CURVE : ST_POW_W;
			ST_POW_W:   if (mrsp.done) state_d = ST_POW;
			ST_SIN_Z:   state_d = ST_SIN_W;
			ST_SIN_W:   if (mrsp.done) state_d = ST_SIN;
			ST_SIN:     if (it_q == 4'd15) state_d = ST_CURVE;
			ST_EXP_PRE: state_d = (x_q == '0) ? ST_CURVE : ST_EXP_SQ;
			ST_EXP_SQ:  state_d = ST_EXP_W;
			ST_EXP_W:   if (sq_done) state_d = (it_q == 4'd15) ? ST_EXP_FIN : ST_EXP_SQ;
			ST_EXP_FIN: state_d = ST_CURVE;
			ST_CIRC_SQ: state_d = ST_CIRC_W;
			ST_CIRC_W:  if (sq_done) state_d = ST_CURVE;
			ST_BNC_SQ:  state_d = ST_BNC_W;
			ST_BNC_W:   if (mrsp.done) state_d = ST_CURVE;
			ST_CURVE:   state_d = ST_SCALE;
			ST_SCALE:   state_d = ST_SCALE_W;
			ST_SCALE_W: if (mrsp.done) state_d = ST_FINAL;
			ST_FINAL:   state_d = ST_OUT;
			ST_OUT:     state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// unit commands
	always_comb begin
		mreq.start = 1'b0;
		mreq.a     = '0;
		mreq.b     = '0;
		sq_start   = 1'b0;
		sq_rad     = '0;
		case (state_q)
			ST_POW: begin
				mreq.start = (pcnt_q != 3'd0);
				mreq.a     = 34'(r_q);
				mreq.b     = 34'($signed({1'b0, x_q}));
			end
			ST_SIN_Z: begin
				mreq.start = 1'b1;
				mreq.a     = 34'($signed({1'b0, x_q}));
				mreq.b     = 34'($signed({2'b0, HALF_PI_Q24}));
			end
			ST_BNC_SQ: begin
				mreq.start = 1'b1;
				mreq.a     = 34'(bu);
				mreq.b     = 34'(bu);
			end
			ST_SCALE: begin
				mreq.start = 1'b1;
				mreq.a     = 34'($signed({b_q[VALUE_WIDTH-1], b_q}) - $signed({a_q[VALUE_WIDTH-1], a_q}));
				mreq.b     = 34'($signed({1'b0, f_q}));
			end
			ST_EXP_SQ: begin
				sq_start = 1'b1;
				sq_rad   = (ef_q[it_q] ? (ey_q << 1) : ey_q) << 30;
			end
			ST_CIRC_SQ: begin
				sq_start = 1'b1;
				sq_rad   = 64'h1_0000_0000 - 64'(x_q[16:0]) * 64'(x_q[16:0]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	// datapath
	logic signed [67:0] vfin;
	logic signed [39:0] cy_last;
	always_comb begin
		vfin = 68'(a_q) * (68'sd1 <<< FRACTION_BITS) + rsh(mrsp.p, 16 - FRACTION_BITS);
	end

	// last CORDIC y update
	assign cy_last = (cz_q >= 0) ? (cy_q + sx) : (cy_q - sx);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) begin
				op_q   <= in_data.opcode;
				a_q    <= in_data.start_value;
				b_q    <= in_data.end_value;
				kind_q <= op_kind(in_data.opcode);
				form_q <= op_form(in_data.opcode);
				out_data.eased_value <= '0;
				out_data.error_code  <= (in_data.opcode > OP_LAST) ? ERR_OPCODE :
					(in_data.duration == '0) ? ERR_DURATION : ERR_NONE;
			end
			ST_DIV: if (div_done) p_q <= div_quo;
			ST_PREP: begin
				f_q    <= p_q;
				it_q   <= '0;
				r_q    <= 40'(arg_in);
				pcnt_q <= 3'(kind_q);
				case (kind_q)
					KIND_SINE, KIND_BOUNCE: x_q <= 18'(QONE) - arg_in;
					default:                x_q <= arg_in;
				endcase
				ey_q <= 64'h4000_0000;
			end
			ST_POW: if (pcnt_q == 3'd0) g_q <= r_q[16:0];
			ST_POW_W: if (mrsp.done) begin
				r_q    <= 40'(rsh(mrsp.p, 16));
				pcnt_q <= pcnt_q - 3'd1;
			end
			ST_SIN_W: if (mrsp.done) begin
				cz_q <= 40'(rsh(mrsp.p, 16));
				cx_q <= 40'(CORDIC_K);
				cy_q <= '0;
			end
			ST_SIN: begin
				if (cz_q >= 0) begin
					cx_q <= cx_q - sy; cy_q <= cy_q + sx; cz_q <= cz_q - 40'(at);
				end else begin
					cx_q <= cx_q + sy; cy_q <= cy_q - sx; cz_q <= cz_q + 40'(at);
				end
				it_q <= it_q + 4'd1;
				if (it_q == 4'd15)
					g_q <= clamp_unit(40'sd65536 - 40'(clamp_unit(40'(rsh(68'(
						cy_last), 8)))));
			end
			ST_EXP_PRE: begin
				g_q  <= '0;
				ek_q <= 4'(ek);
				ef_q <= 17'(({16'd0, ek} << 16) - {16'd0, em});
			end
			ST_EXP_W: if (sq_done) begin
				ey_q <= 64'(sq_root);
				it_q <= it_q + 4'd1;
			end
			ST_EXP_FIN: g_q <= clamp_unit(40'(rsh(68'(ey_q), 14 + int'(ek_q))));
			ST_CIRC_W: if (sq_done) g_q <= clamp_unit(40'sd65536 - 40'(sq_root));
			ST_BNC_W: if (mrsp.done)
				g_q <= clamp_unit(40'sd65536 - 40'(clamp_unit(40'(rsh(mrsp.p, 20)) + badd_q)));
			ST_BNC_SQ: badd_q <= badd;
			ST_CURVE: begin
				case (form_q)
					FORM_IN:  f_q <= g_q;
					FORM_OUT: f_q <= 17'(QONE - g_q);
					default:  f_q <= (p_q < QHALF) ? 17'((18'(g_q) + 18'd1) >> 1) :
						17'(QONE - 17'((18'(g_q) + 18'd1) >> 1));
				endcase
			end
			ST_FINAL: begin
				if (vfin > 68'sd8388607)
					out_data.eased_value <= 24'sh7FFFFF;
				else if (vfin < -68'sd8388608)
					out_data.eased_value <= 24'sh800000;
				else
					out_data.eased_value <= vfin[23:0];
			end
			default: ;
		endcase
	end

	// error results never carry a value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error_code != ERR_NONE |-> out_data.eased_value == '0)
		else $error("error result with nonzero value");
	// no request taken while a result is held
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall)
		else $error("request accepted over held result");
	// the divider only runs with a valid duration
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> in_data.duration != '0)
		else $error("divide by zero started");

endmodule

FILE: sv/eci_mul.sv
// ----------------------------------------------------------------------------
// eci_mul
// Shift-and-add signed multiplier, two multiplier bits per cycle.
// ----------------------------------------------------------------------------
module eci_mul import eci_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  eci_mul_req_t  req,
	output eci_mul_rsp_t  rsp
);

	logic               busy_q;
	logic               done_q;
	logic [4:0]         cnt_q;
	logic signed [67:0] acc_q;
	logic signed [67:0] mcand_q;
	logic [33:0]        mplier_q;
	logic               neg_q;
	logic [33:0]        abs_b;
	logic signed [67:0] add_v;

	assign abs_b = req.b[33] ? 34'(-req.b) : req.b;

	// two partial products per cycle
	always_comb begin
		add_v = acc_q;
		if (mplier_q[0])
			add_v = add_v + mcand_q;
		if (mplier_q[1])
			add_v = add_v + (mcand_q <<< 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd17;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			mcand_q  <= 68'(req.a);
			mplier_q <= abs_b;
			neg_q    <= req.b[33];
		end else if (busy_q) begin
			acc_q    <= add_v;
			mcand_q  <= mcand_q <<< 2;
			mplier_q <= mplier_q >> 2;
		end
	end

	assign rsp.done = done_q;
	assign rsp.p    = neg_q ? -acc_q : acc_q;

endmodule

FILE: sv/eci_sqrt.sv
// ----------------------------------------------------------------------------
// eci_sqrt
// Digit-by-digit rounded square root of a 64-bit value, one digit per cycle.
// ----------------------------------------------------------------------------
module eci_sqrt import eci_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [32:0] root
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] v_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// one result bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = (v_q > res_q) ? 33'(res_q + 64'd1) : 33'(res_q);

endmodule

FILE: sv/eci_div.sv
// ----------------------------------------------------------------------------
// eci_div
// Restoring divider for the progress fraction, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eci_div import eci_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [TIME_WIDTH-1:0] num,
	input  logic [TIME_WIDTH-1:0] den,
	output logic                  done,
	output logic [16:0]           quo
);

	localparam int NW = TIME_WIDTH + 17;
	localparam int CW = $clog2(NW + 1);

	logic                  busy_q;
	logic [CW-1:0]         cnt_q;
	logic [NW-1:0]         n_q;
	logic [TIME_WIDTH:0]   r_q;
	logic [TIME_WIDTH-1:0] d_q;
	logic [TIME_WIDTH:0]   r_sh;

	assign r_sh = {r_q[TIME_WIDTH-1:0], n_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= {1'b0, num, 16'd0};
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			if (r_sh >= {1'b0, d_q}) begin
				r_q <= r_sh - {1'b0, d_q};
				n_q <= {n_q[NW-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				n_q <= {n_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = n_q[16:0];

endmodule
